// ===== src/scmc_pkg.sv =====
package scmc_pkg;

  // Default depth of the step table.
  localparam int SCMC_MAX_STEPS = 8;

  // Field widths of the item and result ports.
  localparam int FV_W    = 13;
  localparam int CUR_W   = 12;
  localparam int STEP_W  = 3;
  localparam int COUNT_W = 4;
  localparam int GAP_W   = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_GAP = 4'd1;

  localparam logic [GAP_W-1:0] GAP_RESET = 8'd25;

  // Item kind code for a table load.
  localparam logic KIND_LOAD = 1'b1;

  // One step table entry as stored in the RAM.
  typedef struct packed {
    logic [FV_W-1:0]  fv;
    logic [CUR_W-1:0] ichg;
    logic [CUR_W-1:0] cc_exit;
    logic [CUR_W-1:0] cv_exit;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Charging modes.
  typedef enum logic [2:0] {
    MODE_CC        = 3'd0,
    MODE_CC_ADJ    = 3'd1,
    MODE_CV_CHECK  = 3'd2,
    MODE_CV_PRESET = 3'd3,
    MODE_CV        = 3'd4,
    MODE_CV_ADJ    = 3'd5,
    MODE_CHANGE    = 3'd6
  } mode_t;

  // Vote set codes, used for both release and apply.
  typedef enum logic [1:0] {
    VOTE_NONE = 2'd0,
    VOTE_CC   = 2'd1,
    VOTE_CV   = 2'd2
  } vote_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clear;
    logic search_init;
    logic search_next;
    logic search_enter;
    logic eval;
    logic addr_search;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_load;
    logic stop;
    logic hold;
    logic active;
    logic empty;
    logic search_more;
  } dp_status_t;

endpackage

// ===== src/scmc_ram.sv =====
module scmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/scmc_ctrl.sv =====
module scmc_ctrl import scmc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output logic       done,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_SRCH_RD  = 7'b0000100,
    S_SRCH_CHK = 7'b0001000,
    S_EVAL     = 7'b0010000,
    S_FETCH    = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  // State register and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_DONE);
    end
  end

  // Sequencing of one item.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status.is_load) begin
          state_next = S_DONE;
        end else if (status.stop) begin
          cmd.clear  = 1'b1;
          state_next = S_DONE;
        end else if (status.hold) begin
          state_next = S_DONE;
        end else if (!status.active) begin
          if (status.empty) begin
            state_next = S_DONE;
          end else begin
            cmd.search_init = 1'b1;
            state_next      = S_SRCH_RD;
          end
        end else begin
          state_next = S_EVAL;
        end
      end
      S_SRCH_RD: begin
        cmd.addr_search = 1'b1;
        state_next      = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        cmd.addr_search = 1'b1;
        if (status.search_more) begin
          cmd.search_next = 1'b1;
          state_next      = S_SRCH_RD;
        end else begin
          cmd.search_enter = 1'b1;
          state_next       = S_DONE;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/scmc_dpath.sv =====
module scmc_dpath import scmc_pkg::*; #(
  parameter int MAX_STEPS = SCMC_MAX_STEPS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  kind,
  input  logic                  charging,
  input  logic                  thermal_ok,
  input  logic                  hold_active,
  input  logic [FV_W-1:0]       average_voltage,
  input  logic [FV_W-1:0]       present_voltage,
  input  logic [CUR_W-1:0]      input_current,
  input  logic [STEP_W-1:0]     entry_index,
  input  logic [FV_W-1:0]       entry_voltage,
  input  logic [CUR_W-1:0]      entry_charge_current,
  input  logic [CUR_W-1:0]      entry_cc_exit,
  input  logic [CUR_W-1:0]      entry_cv_exit,
  output logic                  step_valid,
  output logic [STEP_W-1:0]     step_number,
  output logic [2:0]            mode_now,
  output logic [1:0]            release_vote,
  output logic [1:0]            apply_vote,
  output logic                  clear_all,
  output logic [FV_W-1:0]       voltage_target,
  output logic [CUR_W-1:0]      current_target
);

  localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CNT_W = $clog2(MAX_STEPS + 1);
  localparam int W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [W-1:0] MAX_W = W'(MAX_STEPS);

  logic [COUNT_W-1:0] step_count;
  logic [GAP_W-1:0]   voltage_gap;
  logic [W-1:0]       vcount;

  logic               kind_q;
  logic               charging_q;
  logic               thermal_q;
  logic               hold_q;
  logic [FV_W-1:0]    vavg_q;
  logic [FV_W-1:0]    vnow_q;
  logic [CUR_W-1:0]   iin_q;

  logic               act_flag;
  logic [IDX_W-1:0]   act_step;
  mode_t              mode;
  vote_t              rel;
  vote_t              app;
  logic               clr;
  logic [IDX_W-1:0]   idx;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_raddr;
  entry_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd;

  logic [W-1:0]       step_plus;
  logic [W-1:0]       idx_plus;
  logic               next_ok;
  logic [FV_W:0]      cc_floor;

  mode_t              ev_mode;
  logic [IDX_W-1:0]   ev_step;
  vote_t              ev_rel;
  vote_t              ev_app;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count  <= '0;
      voltage_gap <= GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_COUNT:  step_count  <= cfg_data[COUNT_W-1:0];
        REG_VOLTAGE_GAP: voltage_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  // Number of usable entries, capped at the table depth.
  assign vcount = (W'(step_count) > MAX_W) ? MAX_W : W'(step_count);

  // Monitor fields are held for the length of the item.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q     <= kind;
      charging_q <= charging;
      thermal_q  <= thermal_ok;
      hold_q     <= hold_active;
      vavg_q     <= average_voltage;
      vnow_q     <= present_voltage;
      iin_q      <= input_current;
    end
  end

  // Step table: a load item writes its entry on the transfer edge.
  assign ram_we = cmd.accept && (kind == KIND_LOAD) && (int'(entry_index) < MAX_STEPS);
  assign ram_wdata.fv      = entry_voltage;
  assign ram_wdata.ichg    = entry_charge_current;
  assign ram_wdata.cc_exit = entry_cc_exit;
  assign ram_wdata.cv_exit = entry_cv_exit;
  assign ram_raddr = cmd.addr_search ? idx : act_step;
  assign rd        = entry_t'(ram_rdata);

  scmc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_STEPS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(entry_index)),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Neighbour indexes and comparisons.
  assign step_plus = W'(act_step) + W'(1);
  assign idx_plus  = W'(idx) + W'(1);
  assign next_ok   = (step_plus < vcount);
  assign cc_floor  = (FV_W + 1)'(vnow_q) + (FV_W + 1)'(voltage_gap);

  // Status towards the controller.
  assign status.is_load     = (kind_q == KIND_LOAD);
  assign status.stop        = !charging_q || !thermal_q;
  assign status.hold        = hold_q;
  assign status.active      = act_flag;
  assign status.empty       = (vcount == '0);
  assign status.search_more = (idx_plus < vcount) && (rd.fv < vavg_q);

  // Mode transition of the active step.
  always_comb begin
    ev_mode = mode;
    ev_step = act_step;
    ev_rel  = VOTE_NONE;
    ev_app  = VOTE_NONE;
    case (mode)
      MODE_CC, MODE_CC_ADJ: begin
        if ((FV_W + 1)'(rd.fv) > cc_floor) begin
          ev_mode = MODE_CC;
        end else if (rd.cc_exit > iin_q) begin
          ev_mode = mode_t'(mode + 3'd1);
        end else begin
          ev_mode = MODE_CC;
        end
      end
      MODE_CV_CHECK: begin
        ev_rel = VOTE_CC;
        if (rd.cv_exit > iin_q) begin
          if (next_ok) begin
            ev_step = step_plus[IDX_W-1:0];
            ev_mode = MODE_CC;
            ev_app  = VOTE_CC;
          end
        end else begin
          ev_app  = VOTE_CV;
          ev_mode = MODE_CV;
        end
      end
      MODE_CV_PRESET: begin
        ev_app  = VOTE_CV;
        ev_mode = MODE_CV;
      end
      MODE_CV, MODE_CV_ADJ: begin
        ev_mode = (rd.cv_exit > iin_q) ? mode_t'(mode + 3'd1) : MODE_CV;
      end
      MODE_CHANGE: begin
        ev_rel = VOTE_CV;
        if (next_ok) begin
          ev_step = step_plus[IDX_W-1:0];
          ev_mode = MODE_CC;
          ev_app  = VOTE_CC;
        end
      end
      default: ;
    endcase
  end

  // Step, mode, search index and the votes of the current item.
  always_ff @(posedge clk) begin
    if (rst) begin
      act_flag <= 1'b0;
      act_step <= '0;
      mode     <= MODE_CC;
      rel      <= VOTE_NONE;
      app      <= VOTE_NONE;
      clr      <= 1'b0;
      idx      <= '0;
    end else begin
      if (cmd.accept) begin
        rel <= VOTE_NONE;
        app <= VOTE_NONE;
        clr <= 1'b0;
      end
      if (cmd.clear) begin
        act_flag <= 1'b0;
        act_step <= '0;
        mode     <= MODE_CC;
        clr      <= 1'b1;
      end
      if (cmd.search_init) begin
        idx <= '0;
      end
      if (cmd.search_next) begin
        idx <= idx_plus[IDX_W-1:0];
      end
      if (cmd.search_enter) begin
        act_flag <= 1'b1;
        act_step <= idx;
        mode     <= MODE_CC;
        app      <= VOTE_CC;
      end
      if (cmd.eval) begin
        act_step <= ev_step;
        mode     <= ev_mode;
        rel      <= ev_rel;
        app      <= ev_app;
      end
    end
  end

  // Result registers, loaded once per item.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      step_valid     <= act_flag;
      step_number    <= act_flag ? STEP_W'(act_step) : '0;
      mode_now       <= mode;
      release_vote   <= rel;
      apply_vote     <= app;
      clear_all      <= clr;
      voltage_target <= act_flag ? rd.fv : '0;
      current_target <= act_flag ? rd.ichg : '0;
    end
  end

endmodule

// ===== src/step_charging_mode_controller_unit.sv =====
// Step-charging mode controller.
//
// Items enter on a command channel: an item transfers at a rising edge with
// start high and busy low. kind selects a table load (one step entry written)
// or a monitor tick. A tick with charging or thermal_ok low clears the step,
// one with hold_active high keeps it; any other advances the charging mode of
// the active step or, with no step active, searches the table for the first
// entry at or above the average voltage, else the last valid one. Every item
// gives exactly one result, shown on the result ports for one cycle with done
// high; the receiver cannot stall it. Configuration registers are written over
// the cfg channel (cfg_ready is always high) while the block is idle; the user
// must keep to this, as the block itself does not enforce it.
//
// A load, stop, power hold or empty table goes from dispatch straight to done;
// a mode step passes evaluate and fetch first; a search passes read and check
// per entry examined, as the table has one read port. busy falls in the done
// cycle, so the next item may transfer there. Reset clears the step, mode and
// step count, sets the gap to GAP_RESET; the table is undefined until loaded.
module step_charging_mode_controller_unit import scmc_pkg::*; #(
  parameter int MAX_STEPS = SCMC_MAX_STEPS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  output logic                  done,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  kind,
  input  logic                  charging,
  input  logic                  thermal_ok,
  input  logic                  hold_active,
  input  logic [FV_W-1:0]       average_voltage,
  input  logic [FV_W-1:0]       present_voltage,
  input  logic [CUR_W-1:0]      input_current,
  input  logic [STEP_W-1:0]     entry_index,
  input  logic [FV_W-1:0]       entry_voltage,
  input  logic [CUR_W-1:0]      entry_charge_current,
  input  logic [CUR_W-1:0]      entry_cc_exit,
  input  logic [CUR_W-1:0]      entry_cv_exit,
  output logic                  step_valid,
  output logic [STEP_W-1:0]     step_number,
  output logic [2:0]            mode_now,
  output logic [1:0]            release_vote,
  output logic [1:0]            apply_vote,
  output logic                  clear_all,
  output logic [FV_W-1:0]       voltage_target,
  output logic [CUR_W-1:0]      current_target
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer for one item at a time.
  scmc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  // Step table, mode state and result registers.
  scmc_dpath #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dpath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .status               (status),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .kind                 (kind),
    .charging             (charging),
    .thermal_ok           (thermal_ok),
    .hold_active          (hold_active),
    .average_voltage      (average_voltage),
    .present_voltage      (present_voltage),
    .input_current        (input_current),
    .entry_index          (entry_index),
    .entry_voltage        (entry_voltage),
    .entry_charge_current (entry_charge_current),
    .entry_cc_exit        (entry_cc_exit),
    .entry_cv_exit        (entry_cv_exit),
    .step_valid           (step_valid),
    .step_number          (step_number),
    .mode_now             (mode_now),
    .release_vote         (release_vote),
    .apply_vote           (apply_vote),
    .clear_all            (clear_all),
    .voltage_target       (voltage_target),
    .current_target       (current_target)
  );

endmodule

// ===== src/scmc_checker.sv =====
module scmc_checker import scmc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic              step_valid,
  input logic [STEP_W-1:0] step_number,
  input logic [2:0]        mode_now,
  input logic [1:0]        release_vote,
  input logic [1:0]        apply_vote,
  input logic              clear_all,
  input logic [FV_W-1:0]   voltage_target,
  input logic [CUR_W-1:0]  current_target
);

  // A result is only shown once the item has left the block.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // An item transfer always makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer did not start an item");

  // The done state is never entered straight from idle, so strobes never follow back to back.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // With no step active the step and target fields are zero.
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    (done && !step_valid) |->
      (step_number == '0 && voltage_target == '0 && current_target == '0))
    else $error("fields not zero with no step active");

  // A stop result drops the step, returns to CC and moves no vote set.
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (done && clear_all) |->
      (!step_valid && mode_now == MODE_CC && release_vote == VOTE_NONE &&
       apply_vote == VOTE_NONE))
    else $error("stop result carries step state or votes");

endmodule

bind step_charging_mode_controller_unit scmc_checker u_scmc_checker (.*);

// ===== tb/scmc_outcome_checker.sv =====
// Watches the item, result and register channels of the step-charging
// controller, keeps its own copy of the charging state and compares every
// result with the outcome it predicts.
module scmc_outcome_checker import scmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  done,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  kind,
  input  logic                  charging,
  input  logic                  thermal_ok,
  input  logic                  hold_active,
  input  logic [FV_W-1:0]       average_voltage,
  input  logic [FV_W-1:0]       present_voltage,
  input  logic [CUR_W-1:0]      input_current,
  input  logic [STEP_W-1:0]     entry_index,
  input  logic [FV_W-1:0]       entry_voltage,
  input  logic [CUR_W-1:0]      entry_charge_current,
  input  logic [CUR_W-1:0]      entry_cc_exit,
  input  logic [CUR_W-1:0]      entry_cv_exit,
  input  logic                  step_valid,
  input  logic [STEP_W-1:0]     step_number,
  input  logic [2:0]            mode_now,
  input  logic [1:0]            release_vote,
  input  logic [1:0]            apply_vote,
  input  logic                  clear_all,
  input  logic [FV_W-1:0]       voltage_target,
  input  logic [CUR_W-1:0]      current_target,
  output int                    mismatch_count,
  output int                    results_owed
);

  // One result as it appears on the result ports.
  typedef struct packed {
    logic              step_valid;
    logic [STEP_W-1:0] step_number;
    logic [2:0]        mode_now;
    vote_t             release_vote;
    vote_t             apply_vote;
    logic              clear_all;
    logic [FV_W-1:0]   voltage_target;
    logic [CUR_W-1:0]  current_target;
  } outcome_t;

  // Shadow of the controller state and its registers.
  entry_t             step_entries [SCMC_MAX_STEPS];
  logic [COUNT_W-1:0] step_count_q;
  logic [GAP_W-1:0]   gap_q;
  logic               active_q;
  logic [STEP_W-1:0]  step_q;
  mode_t              mode_q;

  outcome_t pending_outcomes [$];
  outcome_t owed;
  outcome_t seen;

  // Counts above the table depth behave as a full table.
  function automatic int usable_steps();
    return (int'(step_count_q) > SCMC_MAX_STEPS) ? SCMC_MAX_STEPS : int'(step_count_q);
  endfunction

  // Makes the given step active in CC, if the table holds it.
  function automatic bit try_enter(input int idx);
    if (idx >= usable_steps()) return 1'b0;
    active_q = 1'b1;
    step_q   = STEP_W'(idx);
    mode_q   = MODE_CC;
    return 1'b1;
  endfunction

  // Applies the item on the ports to the shadow state and returns the result
  // it should produce.
  function automatic outcome_t next_charge_outcome();
    outcome_t o;
    int       n;
    int       idx;
    entry_t   e;
    o = '0;
    if (kind == KIND_LOAD) begin
      step_entries[entry_index] = '{fv: entry_voltage, ichg: entry_charge_current,
                                    cc_exit: entry_cc_exit, cv_exit: entry_cv_exit};
    end else if (!charging || !thermal_ok) begin
      active_q    = 1'b0;
      step_q      = '0;
      mode_q      = MODE_CC;
      o.clear_all = 1'b1;
    end else if (hold_active) begin
      // Power hold keeps everything as it is.
    end else if (!active_q) begin
      // Search for the first entry at or above the average voltage, stopping
      // at the last valid one.
      n = usable_steps();
      if (n > 0) begin
        idx = 0;
        while (idx + 1 < n && step_entries[idx].fv < average_voltage) idx++;
        if (try_enter(idx)) o.apply_vote = VOTE_CC;
      end
    end else begin
      e = step_entries[step_q];
      case (mode_q)
        MODE_CC, MODE_CC_ADJ: begin
          // The margin test is signed: a float voltage below the gap never
          // holds the step in CC.
          if (int'(e.fv) - int'(gap_q) > int'(present_voltage)) mode_q = MODE_CC;
          else if (e.cc_exit > input_current) mode_q = mode_t'(mode_q + 3'd1);
          else mode_q = MODE_CC;
        end
        MODE_CV_CHECK: begin
          o.release_vote = VOTE_CC;
          if (e.cv_exit > input_current) begin
            if (try_enter(int'(step_q) + 1)) o.apply_vote = VOTE_CC;
          end else begin
            o.apply_vote = VOTE_CV;
            mode_q       = MODE_CV;
          end
        end
        MODE_CV_PRESET: begin
          o.apply_vote = VOTE_CV;
          mode_q       = MODE_CV;
        end
        MODE_CV, MODE_CV_ADJ: begin
          mode_q = (e.cv_exit > input_current) ? mode_t'(mode_q + 3'd1) : MODE_CV;
        end
        MODE_CHANGE: begin
          o.release_vote = VOTE_CV;
          if (try_enter(int'(step_q) + 1)) o.apply_vote = VOTE_CC;
        end
        default: begin
        end
      endcase
    end
    o.step_valid     = active_q;
    o.step_number    = active_q ? step_q : '0;
    o.mode_now       = mode_q;
    o.voltage_target = active_q ? step_entries[step_q].fv : '0;
    o.current_target = active_q ? step_entries[step_q].ichg : '0;
    return o;
  endfunction

  // Register writes, result checks and predictions, in that order, so that a
  // result is never matched with the item that transfers at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      step_count_q = '0;
      gap_q        = GAP_RESET;
      active_q     = 1'b0;
      step_q       = '0;
      mode_q       = MODE_CC;
      pending_outcomes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_STEP_COUNT) step_count_q = cfg_data[COUNT_W-1:0];
        else if (cfg_index == REG_VOLTAGE_GAP) gap_q = cfg_data;
      end
      if (done) begin
        seen = {step_valid, step_number, mode_now, release_vote, apply_vote, clear_all,
                voltage_target, current_target};
        if (pending_outcomes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Result with nothing expected: valid=%0d step=%0d mode=%0d",
                     seen.step_valid, seen.step_number, seen.mode_now);
        end else begin
          owed = pending_outcomes.pop_front();
          if (seen !== owed) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("Mismatch: expected valid=%0d step=%0d mode=%0d rel=%0d app=%0d clr=%0d v=%0d i=%0d",
                       owed.step_valid, owed.step_number, owed.mode_now, owed.release_vote,
                       owed.apply_vote, owed.clear_all, owed.voltage_target, owed.current_target);
              $display("          actual   valid=%0d step=%0d mode=%0d rel=%0d app=%0d clr=%0d v=%0d i=%0d",
                       seen.step_valid, seen.step_number, seen.mode_now, seen.release_vote,
                       seen.apply_vote, seen.clear_all, seen.voltage_target, seen.current_target);
            end
          end
        end
      end
      if (start && !busy) pending_outcomes.push_back(next_charge_outcome());
    end
    results_owed <= pending_outcomes.size();
  end

endmodule

// ===== tb/tb_step_charging_mode_controller_unit.sv =====
module tb_step_charging_mode_controller_unit;
  import scmc_pkg::*;

  // An index with no register behind it: a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd9;
  localparam int RUN_LIMIT  = 2000000;
  localparam int PHASE_LEN  = 205;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  done;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  kind;
  logic                  charging;
  logic                  thermal_ok;
  logic                  hold_active;
  logic [FV_W-1:0]       average_voltage;
  logic [FV_W-1:0]       present_voltage;
  logic [CUR_W-1:0]      input_current;
  logic [STEP_W-1:0]     entry_index;
  logic [FV_W-1:0]       entry_voltage;
  logic [CUR_W-1:0]      entry_charge_current;
  logic [CUR_W-1:0]      entry_cc_exit;
  logic [CUR_W-1:0]      entry_cv_exit;
  logic                  step_valid;
  logic [STEP_W-1:0]     step_number;
  logic [2:0]            mode_now;
  logic [1:0]            release_vote;
  logic [1:0]            apply_vote;
  logic                  clear_all;
  logic [FV_W-1:0]       voltage_target;
  logic [CUR_W-1:0]      current_target;
  int                    mismatch_count;
  int                    results_owed;

  bit no_idle;
  int item_total;
  int load_total;
  int stop_total;
  int hold_total;
  int setting_total;

  step_charging_mode_controller_unit DUT (.*);

  scmc_outcome_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #RUN_LIMIT;
    $display("FAILURE");
    $finish;
  end

  // Holds start until the item transfers, then sometimes leaves a gap.
  task automatic transfer_item();
    start <= 1'b1;
    do @(posedge clk); while (busy);
    item_total++;
    if (!no_idle && $urandom_range(99) < 29) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic tick(input bit chg, input bit thr, input bit hld,
                      input logic [FV_W-1:0] vavg, input logic [FV_W-1:0] vnow,
                      input logic [CUR_W-1:0] iin);
    kind                 <= ~KIND_LOAD;
    charging             <= chg;
    thermal_ok           <= thr;
    hold_active          <= hld;
    average_voltage      <= vavg;
    present_voltage      <= vnow;
    input_current        <= iin;
    entry_index          <= STEP_W'($urandom);
    entry_voltage        <= FV_W'($urandom);
    entry_charge_current <= CUR_W'($urandom);
    entry_cc_exit        <= CUR_W'($urandom);
    entry_cv_exit        <= CUR_W'($urandom);
    if (!chg || !thr) stop_total++;
    else if (hld) hold_total++;
    transfer_item();
  endtask

  task automatic load_entry(input logic [STEP_W-1:0] idx, input logic [FV_W-1:0] fv,
                            input logic [CUR_W-1:0] ichg, input logic [CUR_W-1:0] cc_exit,
                            input logic [CUR_W-1:0] cv_exit);
    kind                 <= KIND_LOAD;
    charging             <= 1'($urandom);
    thermal_ok           <= 1'($urandom);
    hold_active          <= 1'($urandom);
    average_voltage      <= FV_W'($urandom);
    present_voltage      <= FV_W'($urandom);
    input_current        <= CUR_W'($urandom);
    entry_index          <= idx;
    entry_voltage        <= fv;
    entry_charge_current <= ichg;
    entry_cc_exit        <= cc_exit;
    entry_cv_exit        <= cv_exit;
    load_total++;
    transfer_item();
  endtask

  // Stops sending until every owed result has arrived.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // Writes both registers back to back, valid held high throughout; the
  // spare index is optionally written first.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] count_data,
                              input logic [CFG_DATA_W-1:0] gap_data, input bit with_spare);
    cfg_valid <= 1'b1;
    if (with_spare) begin
      cfg_index <= REG_SPARE;
      cfg_data  <= CFG_DATA_W'($urandom);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_index <= REG_STEP_COUNT;
    cfg_data  <= count_data;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_VOLTAGE_GAP;
    cfg_data  <= gap_data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    setting_total++;
  endtask

  initial begin
    int              k;
    int              r;
    int              s;
    int              waited;
    int              leftover;
    logic [FV_W-1:0] vavg;
    logic [FV_W-1:0] vnow;
    logic [CUR_W-1:0] iin;
    logic [3:0]      counts [6];
    logic [7:0]      gaps [6];
    counts = '{4'd8, 4'd2, 4'd15, 4'd0, 4'd1, 4'd5};
    gaps   = '{8'd25, 8'd0, 8'd255, 8'd120, 8'd255, 8'd0};
    no_idle       = 1'b0;
    item_total    = 0;
    load_total    = 0;
    stop_total    = 0;
    hold_total    = 0;
    setting_total = 0;

    rst                  <= 1'b1;
    start                <= 1'b0;
    cfg_valid            <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    kind                 <= 1'b0;
    charging             <= 1'b0;
    thermal_ok           <= 1'b0;
    hold_active          <= 1'b0;
    average_voltage      <= '0;
    present_voltage      <= '0;
    input_current        <= '0;
    entry_index          <= '0;
    entry_voltage        <= '0;
    entry_charge_current <= '0;
    entry_cc_exit        <= '0;
    entry_cv_exit        <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // After reset the table counts as empty, so no tick may select a step.
    tick(1'b1, 1'b1, 1'b0, 13'd4000, 13'd4000, 12'd500);
    tick(1'b1, 1'b1, 1'b1, 13'd0, 13'd0, 12'd0);
    tick(1'b0, 1'b1, 1'b0, 13'd8191, 13'd8191, 12'd4095);
    tick(1'b1, 1'b0, 1'b0, 13'd4000, 13'd4000, 12'd500);

    // Fill the whole table before any search can read it: the lowest entry
    // sits at zero volts and the top one at full scale.
    load_entry(3'd0, 13'd0, 12'd4095, 12'd2000, 12'd1000);
    for (k = 1; k < 7; k++)
      load_entry(STEP_W'(k), FV_W'(3600 + 100 * k), CUR_W'(1000 + 100 * k), 12'd800, 12'd400);
    load_entry(3'd7, 13'd8191, 12'd0, 12'd4095, 12'd4095);
    settle();
    program_regs({4'hA, 4'd8}, GAP_RESET, 1'b1);

    // Zero average picks the first entry; its float voltage is below the gap,
    // so the margin goes negative and CC gives way at once.
    tick(1'b1, 1'b1, 1'b0, 13'd0, 13'd0, 12'd0);
    tick(1'b1, 1'b1, 1'b0, 13'd0, 13'd0, 12'd0);
    tick(1'b0, 1'b0, 1'b0, 13'd0, 13'd0, 12'd0);
    // Full-scale average walks the search to the last entry.
    tick(1'b1, 1'b1, 1'b0, 13'd8191, 13'd0, 12'd4095);
    tick(1'b1, 1'b1, 1'b0, 13'd0, 13'd0, 12'd0);
    tick(1'b1, 1'b1, 1'b0, 13'd0, 13'd8191, 12'd0);
    tick(1'b1, 1'b1, 1'b0, 13'd0, 13'd8191, 12'd0);
    // Exit current equal to the input current is not above it: on to CV.
    tick(1'b1, 1'b1, 1'b0, 13'd0, 13'd8191, 12'd4095);
    tick(1'b1, 1'b1, 1'b0, 13'd0, 13'd8191, 12'd0);
    tick(1'b1, 1'b1, 1'b0, 13'd0, 13'd8191, 12'd0);
    // No step beyond the last: the release shows but nothing moves.
    tick(1'b1, 1'b1, 1'b0, 13'd0, 13'd8191, 12'd0);
    tick(1'b1, 1'b1, 1'b1, 13'd8191, 13'd8191, 12'd4095);

    // Random phases, each under its own register setting. The state carries
    // over, so a lowered count can leave a step active beyond it.
    for (int p = 0; p < 6; p++) begin
      settle();
      program_regs({4'($urandom), counts[p]}, gaps[p], 1'($urandom));
      no_idle = (p == 2);
      for (int i = 0; i < PHASE_LEN; i++) begin
        r = $urandom_range(99);
        if (r < 7) begin
          k = $urandom_range(7);
          if ($urandom_range(9) == 0) vavg = FV_W'($urandom_range(0, 8191));
          else vavg = FV_W'(3400 + 140 * k + $urandom_range(0, 250));
          load_entry(STEP_W'(k), vavg, CUR_W'($urandom),
                     ($urandom_range(9) < 8) ? CUR_W'($urandom_range(200, 1500))
                                             : CUR_W'($urandom),
                     ($urandom_range(9) < 8) ? CUR_W'($urandom_range(100, 900))
                                             : CUR_W'($urandom));
        end else if (r < 10) begin
          s = $urandom_range(2);
          tick(s == 1, s == 2, 1'($urandom), FV_W'($urandom), FV_W'($urandom),
               CUR_W'($urandom));
        end else if (r < 15) begin
          tick(1'b1, 1'b1, 1'b1, FV_W'($urandom), FV_W'($urandom), CUR_W'($urandom));
        end else begin
          // Mostly values near the table thresholds, some that push the
          // mode machine forward, and some full-range noise.
          s = $urandom_range(99);
          if (s < 40) begin
            vnow = FV_W'($urandom_range(4400, 8191));
            iin  = CUR_W'($urandom_range(0, 99));
          end else if (s < 85) begin
            vnow = FV_W'($urandom_range(3300, 4700));
            iin  = CUR_W'($urandom_range(0, 1600));
          end else begin
            vnow = FV_W'($urandom);
            iin  = CUR_W'($urandom);
          end
          vavg = ($urandom_range(99) < 85) ? FV_W'($urandom_range(3300, 4500))
                                           : FV_W'($urandom);
          tick(1'b1, 1'b1, 1'b0, vavg, vnow, iin);
        end
        if ($urandom_range(149) == 0) settle();
      end
    end

    // Drain, with a bound, then allow for the longest search latency.
    start <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (results_owed != 0 && waited < 400);
    repeat (24) @(posedge clk);
    leftover = results_owed;

    $display("Covered %0d items: %0d table loads, %0d charge stops, %0d power holds,",
             item_total, load_total, stop_total, hold_total);
    $display("under %0d register settings including empty and full tables and both gap extremes.",
             setting_total);
    if (mismatch_count == 0 && leftover == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
